[src/esf_pkg.sv]
// esf_pkg: shared widths and constants for the encoder spike filter
// no dependencies; imported by encoder_spike_filter_top and tb
package esf_pkg;

   localparam int POS_W      = 14;              // encoder position width
   localparam int DELTA_W    = 15;              // signed tick delta, -8192..8192
   localparam int CHANGE_W   = 16;              // signed delta change, -16384..16384
   localparam int LIMIT_W    = 15;              // acceleration limit register width
   localparam int HALF_RANGE = 8192;            // half a turn in ticks
   localparam int ENC_RANGE  = 16384;           // one full turn in ticks

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2014);

   localparam int HISTORY_DEPTH_DEFAULT = 10;

   typedef logic [POS_W-1:0]          pos_type;
   typedef logic signed [DELTA_W-1:0] delta_type;
   typedef logic signed [CHANGE_W-1:0] change_type;
   typedef logic [LIMIT_W-1:0]        limit_type;

endpackage

[src/encoder_spike_filter_top.sv]
// encoder_spike_filter_top: spike filter for a 14-bit absolute encoder
// depends on esf_pkg for widths, reset limit and default history depth
//
//   channel | ports                      | direction | beat
//   req     | req_valid/req_ready        | in        | req_position
//   rsp     | rsp_valid/rsp_ready        | out       | rsp_filtered_position, rsp_anomaly,
//           |                            |           | rsp_delta_change
//   csr     | csr_we, csr_wdata          | in        | accel limit
//
// one beat per cycle sustained while rsp_ready is held; an accepted beat is presented on rsp after
// the input register, then the result register; the mean uses one constant multiply
// on the running delta sum, so the whole item is done in that single stage
// reset clears the fill count, delta history, sum and limit (back to 2014)
// an item can wait in the input register while a result waits on rsp_ready
module encoder_spike_filter_top
   import esf_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [POS_W-1:0]  req_position,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [POS_W-1:0]  rsp_filtered_position,
   output logic              rsp_anomaly,
   output logic signed [CHANGE_W-1:0] rsp_delta_change,
   input  logic              csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata
);

   localparam int RING_N = HISTORY_DEPTH - 1;
   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = $clog2(RING_N * HALF_RANGE + 1) + 1;
   // rounded mean: (2*|sum| + n) / (2*n), exact reciprocal multiply
   localparam int X_W    = SUM_W + 1;
   localparam int DIV    = 2 * RING_N;
   localparam int DIV_L  = $clog2(DIV);
   localparam int SHIFT  = X_W + DIV_L;
   localparam int RECIP_W = X_W + 1;
   localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + longint'(DIV) - 64'd1) / longint'(DIV);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);

   // configuration
   limit_type limit_ff;

   // input stage
   logic    in_valid_ff;
   pos_type in_pos_ff;

   // filter state
   pos_type                  prev_pos_ff;
   delta_type                ring_ff [RING_N];
   logic signed [SUM_W-1:0]  sum_ff;
   delta_type                last_delta_ff;
   logic [FILL_W-1:0]        fill_cnt_ff;

   // result stage
   logic       rsp_valid_ff;
   pos_type    rsp_pos_ff;
   logic       rsp_anomaly_ff;
   change_type rsp_change_ff;

   logic advance;
   logic filling;
   logic push;
   logic signed [CHANGE_W-1:0] raw_diff;
   logic signed [CHANGE_W-1:0] wrap_diff;
   delta_type  meas_delta;
   change_type change_calc;
   logic [CHANGE_W-1:0] change_mag;
   logic       sum_neg;
   logic [SUM_W-1:0] sum_mag;
   logic [X_W-1:0] div_num;
   logic [X_W+RECIP_W-1:0] div_prod;
   logic [DELTA_W-1:0] mean_mag;
   delta_type  mean_val;
   logic       anomaly_in;
   pos_type    result_in;
   delta_type  delta_in;
   change_type change_in;
   logic signed [SUM_W-1:0] sum_in;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign filling   = fill_cnt_ff < FILL_FULL;
   assign push      = !filling || (fill_cnt_ff != '0);

   always_comb begin
      // wrapped delta into -8192..8192
      raw_diff = $signed({2'b00, in_pos_ff}) - $signed({2'b00, prev_pos_ff});
      wrap_diff = raw_diff;
      if (raw_diff > CHANGE_W'(HALF_RANGE)) begin
         wrap_diff = raw_diff - CHANGE_W'(ENC_RANGE);
      end else if (raw_diff < -CHANGE_W'(HALF_RANGE)) begin
         wrap_diff = raw_diff + CHANGE_W'(ENC_RANGE);
      end
      meas_delta = wrap_diff[DELTA_W-1:0];

      change_calc = $signed({meas_delta[DELTA_W-1], meas_delta})
                  - $signed({last_delta_ff[DELTA_W-1], last_delta_ff});
      change_mag  = change_calc[CHANGE_W-1] ? CHANGE_W'(-change_calc)
                                            : CHANGE_W'(change_calc);

      // mean of stored deltas, rounded half away from zero
      sum_neg  = sum_ff[SUM_W-1];
      sum_mag  = sum_neg ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      div_num  = {sum_mag, 1'b0} + X_W'(RING_N);
      div_prod = (X_W+RECIP_W)'(div_num) * (X_W+RECIP_W)'(RECIP);
      mean_mag = div_prod[SHIFT +: DELTA_W];
      mean_val = sum_neg ? -$signed(mean_mag) : $signed(mean_mag);

      anomaly_in = !filling && (change_mag > {1'b0, limit_ff});
      result_in  = anomaly_in ? pos_type'(prev_pos_ff + pos_type'(mean_val)) : in_pos_ff;
      delta_in   = anomaly_in ? mean_val : meas_delta;
      change_in  = filling ? '0 : change_calc;

      sum_in = sum_ff
             + {{(SUM_W-DELTA_W){delta_in[DELTA_W-1]}}, delta_in}
             - {{(SUM_W-DELTA_W){ring_ff[RING_N-1][DELTA_W-1]}}, ring_ff[RING_N-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_pos_ff <= req_position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pos_ff   <= '0;
         sum_ff        <= '0;
         last_delta_ff <= '0;
         fill_cnt_ff   <= '0;
         for (int i = 0; i < RING_N; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (advance) begin
         prev_pos_ff <= result_in;
         if (filling) begin
            fill_cnt_ff <= fill_cnt_ff + FILL_W'(1);
         end else begin
            last_delta_ff <= delta_in;
         end
         if (push) begin
            sum_ff     <= sum_in;
            ring_ff[0] <= delta_in;
            for (int i = 1; i < RING_N; i++) begin
               ring_ff[i] <= ring_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pos_ff     <= result_in;
         rsp_anomaly_ff <= anomaly_in;
         rsp_change_ff  <= change_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_filtered_position = rsp_pos_ff;
   assign rsp_anomaly           = rsp_anomaly_ff;
   assign rsp_delta_change      = rsp_change_ff;

   // a replaced sample only ever leaves after the history is full
   a_anomaly_after_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_anomaly_ff |-> fill_cnt_ff == FILL_FULL)
      else $error("anomaly flagged before history filled");

   // beats produced while still filling carry no delta change
   a_fill_zero_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (fill_cnt_ff < FILL_FULL) |-> rsp_change_ff == '0)
      else $error("nonzero delta change during fill");

   // a replaced sample stores the mean as its delta
   a_mean_stored: assert property (@(posedge clock) disable iff (reset)
      advance && anomaly_in |=> last_delta_ff == $past(mean_val))
      else $error("mean not stored as last delta");

   // mean of wrapped deltas stays within half a turn
   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      mean_mag <= DELTA_W'(HALF_RANGE))
      else $error("mean magnitude out of range");

   // a waiting input beat is not dropped while the result stalls
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_ready |=> in_valid_ff && $stable(in_pos_ff))
      else $error("input beat lost under stall");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for encoder_spike_filter_top, directed and random position streams
// depends on esf_pkg and the filter rtl; predicts every result beat and checks it in order

module tb
   import esf_pkg::*;
;

   localparam int DEPTH        = HISTORY_DEPTH_DEFAULT;
   localparam int NDELTA       = DEPTH - 1;
   localparam int MAX_CYCLES   = 200000;
   localparam int DRAIN_CYCLES = 6;

   typedef struct packed {
      pos_type    position;
      logic       anomaly;
      change_type change;
   } filter_out_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   pos_type    req_position = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   pos_type    rsp_filtered_position;
   logic       rsp_anomaly;
   change_type rsp_delta_change;
   logic       csr_we = 1'b0;
   limit_type  csr_wdata = '0;

   // filter state as the testbench tracks it
   pos_type   pos_hist [DEPTH];
   int        delta_hist [NDELTA];
   int        delta_total;
   int        pos_slot;
   int        delta_slot;
   int        fill_level;
   int        prev_delta;
   limit_type accel_limit;

   filter_out_type predicted_outputs [$];
   int          mismatch_count = 0;
   int          result_count = 0;
   int          spike_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          gaps_on = 1'b1;
   logic [15:0] ready_mask = 16'hFFFF;
   int          mask_age = 0;

   encoder_spike_filter_top #(
      .HISTORY_DEPTH(DEPTH)
   ) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_position          (req_position),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_filtered_position (rsp_filtered_position),
      .rsp_anomaly           (rsp_anomaly),
      .rsp_delta_change      (rsp_delta_change),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_filter_state();
      for (int i = 0; i < DEPTH; i++) pos_hist[i] = '0;
      for (int i = 0; i < NDELTA; i++) delta_hist[i] = 0;
      delta_total = 0;
      pos_slot    = 0;
      delta_slot  = 0;
      fill_level  = 0;
      prev_delta  = 0;
      accel_limit = LIMIT_RESET;
   endfunction

   // shortest signed distance between two positions on the ring
   function automatic int wrap_ticks(input int from_pos, input int to_pos);
      int d;
      d = to_pos - from_pos;
      if (d > HALF_RANGE) d -= ENC_RANGE;
      if (d < -HALF_RANGE) d += ENC_RANGE;
      return d;
   endfunction

   function automatic void record_delta(input int d);
      delta_total += d - delta_hist[delta_slot];
      delta_hist[delta_slot] = d;
      delta_slot = (delta_slot + 1) % NDELTA;
   endfunction

   // rounded half away from zero
   function automatic int mean_delta();
      int mag;
      int q;
      mag = (delta_total < 0) ? -delta_total : delta_total;
      q = (2 * mag + NDELTA) / (2 * NDELTA);
      return (delta_total < 0) ? -q : q;
   endfunction

   function automatic filter_out_type filter_step(input pos_type sample);
      filter_out_type r;
      int prev_pos;
      int d;
      int mag;
      int m;
      prev_pos   = pos_hist[(pos_slot + DEPTH - 1) % DEPTH];
      r.position = sample;
      r.anomaly  = 1'b0;
      r.change   = '0;
      if (fill_level < DEPTH) begin
         if (fill_level > 0) record_delta(wrap_ticks(prev_pos, sample));
         pos_hist[pos_slot] = sample;
         fill_level++;
      end else begin
         d = wrap_ticks(prev_pos, sample);
         r.change = change_type'(d - prev_delta);
         mag = d - prev_delta;
         if (mag < 0) mag = -mag;
         if (mag > int'(accel_limit)) begin
            m = mean_delta();
            r.anomaly  = 1'b1;
            r.position = pos_type'(prev_pos + m + ENC_RANGE);
            d = m;
         end
         pos_hist[pos_slot] = r.position;
         record_delta(d);
         prev_delta = d;
      end
      pos_slot = (pos_slot + 1) % DEPTH;
      return r;
   endfunction

   // result checker and input-side predictor, both sampled at the edge
   always @(posedge clock) begin
      filter_out_type want;
      if (!reset) begin
         if (csr_we) accel_limit = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (rsp_anomaly) spike_count++;
            if (predicted_outputs.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: unexpected result beat pos=%0d anomaly=%0b change=%0d",
                           rsp_filtered_position, rsp_anomaly, rsp_delta_change);
            end else begin
               want = predicted_outputs.pop_front();
               if (rsp_filtered_position !== want.position || rsp_anomaly !== want.anomaly ||
                   rsp_delta_change !== want.change) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("ERROR: beat %0d expected pos=%0d anomaly=%0b change=%0d, %s",
                              result_count, want.position, want.anomaly,
                              $signed(want.change),
                              $sformatf("got pos=%0d anomaly=%0b change=%0d",
                                        rsp_filtered_position, rsp_anomaly,
                                        rsp_delta_change));
               end
            end
         end
         if (req_valid && req_ready) predicted_outputs.push_back(filter_step(req_position));
      end
   end

   // receiver back-pressure: a rotating mask, reloaded now and then
   always @(posedge clock) begin
      if (mask_age == 0) begin
         mask_age = $urandom_range(64, 16);
         case ($urandom_range(3))
            0:       ready_mask = 16'hFFFF;
            1:       ready_mask = 16'($urandom & $urandom) | 16'h0001;
            default: ready_mask = 16'($urandom) | 16'h0100;
         endcase
      end
      rsp_ready <= ready_mask[0];
      ready_mask = {ready_mask[0], ready_mask[15:1]};
      mask_age--;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= MAX_CYCLES) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, predicted_outputs.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_position(input pos_type p);
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = $urandom_range(12, 1);
      end
      if (burst_left > 0) burst_left--;
      req_valid    <= 1'b1;
      req_position <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   // wait for an edge first so the beat accepted at the last edge is already queued
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input limit_type value);
      wait_for_drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // step from the last stored position; relative steps add the last delta
   task automatic send_step(input int d, input bit relative);
      int last_pos;
      wait_for_drain();
      last_pos = pos_hist[(pos_slot + DEPTH - 1) % DEPTH];
      if (relative) d += prev_delta;
      send_position(pos_type'(last_pos + d));
   endtask

   // pass-through while the history fills, with half-turn and wrap deltas
   task automatic test_fill_passthrough();
      send_position(14'd0);
      send_position(14'd16383);
      send_position(14'd8191);
      send_position(14'd16383);
      send_position(14'd0);
      send_position(14'd8192);
      send_position(14'd0);
      send_position(14'd100);
      send_position(14'd200);
      send_position(14'd300);
   endtask

   // spike at the reset limit, then one whose estimate wraps past full turn
   task automatic test_spike_replacement();
      send_position(14'd400);
      send_position(14'd500);
      send_position(14'd6000);
      write_limit(limit_type'(32767));
      send_position(14'd8000);
      send_position(14'd15500);
      send_position(14'd16300);
      write_limit(limit_type'(2014));
      send_position(14'd5000);
   endtask

   // change exactly at the limit passes, one tick beyond is replaced
   task automatic test_limit_edges();
      send_step(2014, 1'b1);
      send_step(-2015, 1'b1);
      write_limit(limit_type'(32767));
      send_step(0, 1'b0);
      write_limit(limit_type'(0));
      send_step(0, 1'b1);
      send_step(1, 1'b1);
      write_limit(limit_type'(ENC_RANGE));
      send_step(-HALF_RANGE, 1'b0);
      send_step(HALF_RANGE, 1'b0);
      write_limit(limit_type'(ENC_RANGE - 1));
      send_step(-HALF_RANGE, 1'b0);
   endtask

   // smooth trajectories with random content, spikes, sharp turns and noise
   task automatic test_random_tracks(input int n_items, input limit_type lim);
      int      vel;
      pos_type p;
      write_limit(lim);
      gaps_on = ($urandom_range(3) != 0);
      p   = pos_type'($urandom);
      vel = int'($urandom_range(400)) - 200;
      for (int k = 0; k < n_items; k++) begin
         case ($urandom_range(19))
            0: send_position(pos_type'($urandom));
            1: begin
               if ($urandom_range(1))
                  send_position(p + pos_type'($urandom_range(6000, 2500)));
               else
                  send_position(p - pos_type'($urandom_range(6000, 2500)));
            end
            2: begin
               vel = int'($urandom_range(16000)) - 8000;
               p   = p + pos_type'(vel);
               send_position(p);
            end
            default: begin
               vel += int'($urandom_range(60)) - 30;
               if (vel > 8000) vel = 8000;
               if (vel < -8000) vel = -8000;
               p = p + pos_type'(vel);
               send_position(p);
            end
         endcase
      end
   endtask

   // unrelated positions only
   task automatic test_noise(input int n_items);
      write_limit(limit_type'(600));
      gaps_on = 1'b1;
      for (int k = 0; k < n_items; k++) send_position(pos_type'($urandom));
   endtask

   initial begin
      clear_filter_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_fill_passthrough();
      test_spike_replacement();
      test_limit_edges();
      test_random_tracks(100, limit_type'(2014));
      test_random_tracks(100, limit_type'(0));
      test_random_tracks(100, limit_type'($urandom_range(ENC_RANGE, 1)));
      test_random_tracks(100, limit_type'(ENC_RANGE));
      test_random_tracks(100, limit_type'(32767));
      test_random_tracks(100, limit_type'($urandom));
      test_noise(50);
      wait_for_drain();

      $display("checked %0d result beats, %0d replaced as spikes", result_count, spike_count);
      $display("limits swept 0..32767 across fill, spike, wrap and noise streams");
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
